// ----- design/sdp_pkg.sv -----
// Shared types, character codes and helper functions for the decimal parser.
// No dependencies; imported by sdp_parse_core and strict_decimal_to_int64_parser_core.
package sdp_pkg;

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_SIGN   = 3'd1,
    PH_DIGITS = 3'd2,
    PH_TRAIL  = 3'd3,
    PH_ERR    = 3'd4
  } phase_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Both limits (2^63-1 and 2^63) share the same quotient by ten.
  localparam logic [63:0] LIMIT_Q   = 64'd922337203685477580;
  localparam logic [3:0]  POS_LIM_R = 4'd7;
  localparam logic [3:0]  NEG_LIM_R = 4'd8;

  typedef struct packed {
    logic        ok;
    logic [63:0] value;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// ----- design/strict_decimal_to_int64_parser_core.sv -----
// Strict decimal string to signed 64-bit integer parser, top level.
// Depends on sdp_pkg and sdp_parse_core.
//
// Usage:
//   in_*  : one character byte per word; byte 0 terminates the string.
//   out_* : one word per terminator; out_tuser is the ok flag, out_tdata the
//           signed value (0 when ok is low).
//   Accepted form: optional whitespace, optional sign, one or more digits,
//   optional whitespace. Values outside -2^63..2^63-1 give ok low.
//   Non-terminator bytes produce no output word.
// Timing:
//   One byte per cycle sustained, unless a terminator waits on a held output
//   word. A byte is captured in the input register, then the parse step
//   updates state; a terminator's result lands in the output register, so
//   out_tvalid rises once the terminator has passed both registers. Throughput
//   rests on the combinational multiply-by-ten and range compare in the parse step.
// Reset: rst_n low empties both registers and returns to the start phase.
// Stall: while the output word waits, non-terminator bytes keep flowing;
//   a second terminator holds in the input register until the output frees.
module strict_decimal_to_int64_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] value
  output logic        out_tuser   // [0] ok
);
  import sdp_pkg::*;

  logic        ch_valid_r;
  logic [7:0]  ch_r;
  logic        out_valid_r;
  result_t     out_res_r;
  result_t     step_res;
  logic        out_free;
  logic        is_term;
  logic        step_go;

  assign out_free  = !out_valid_r || out_tready;
  assign is_term   = (ch_r == CH_NUL);
  assign step_go   = ch_valid_r && (!is_term || out_free);
  assign in_tready = !ch_valid_r || step_go;

  sdp_parse_core u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_go),
    .ch      (ch_r),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_valid_r <= 1'b0;
    end else if (in_tready) begin
      ch_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      ch_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_go && is_term) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && is_term) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.value;
  assign out_tuser  = out_res_r.ok;

endmodule

// ----- design/sdp_parse_core.sv -----
// Parse state (phase, sign, magnitude) and the per-byte step logic.
// Depends on sdp_pkg. Result is combinational from the registered state alone.
module sdp_parse_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step_en,
  input  logic [7:0]      ch,
  output sdp_pkg::result_t res
);
  import sdp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic        neg_r, neg_nxt;
  logic [63:0] accum_r, accum_nxt;

  logic [3:0]  digit;
  logic [3:0]  lim_rem;
  logic        fits;
  logic [63:0] accum_x10;
  logic        good;

  assign digit     = 4'(ch - CH_ZERO);
  assign lim_rem   = neg_r ? NEG_LIM_R : POS_LIM_R;
  assign fits      = !((accum_r > LIMIT_Q) || ((accum_r == LIMIT_Q) && (digit > lim_rem)));
  // x10 plus digit as shift-add
  assign accum_x10 = (accum_r << 3) + (accum_r << 1) + {60'd0, digit};

  assign good      = (phase_r == PH_DIGITS) || (phase_r == PH_TRAIL);
  assign res.ok    = good;
  assign res.value = good ? (neg_r ? (64'd0 - accum_r) : accum_r) : 64'd0;

  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    accum_nxt = accum_r;
    if (ch == CH_NUL) begin
      phase_nxt = PH_LEAD;
      neg_nxt   = 1'b0;
      accum_nxt = 64'd0;
    end else begin
      unique case (phase_r)
        PH_LEAD: begin
          if (is_space(ch)) begin
            phase_nxt = PH_LEAD;
          end else if ((ch == CH_PLUS) || (ch == CH_MINUS)) begin
            neg_nxt   = (ch == CH_MINUS);
            phase_nxt = PH_SIGN;
          end else if (is_digit(ch)) begin
            phase_nxt = fits ? PH_DIGITS : PH_ERR;
            if (fits) accum_nxt = accum_x10;
          end else begin
            phase_nxt = PH_ERR;
          end
        end
        PH_SIGN, PH_DIGITS: begin
          if (is_digit(ch)) begin
            phase_nxt = fits ? PH_DIGITS : PH_ERR;
            if (fits) accum_nxt = accum_x10;
          end else if (is_space(ch) && (phase_r == PH_DIGITS)) begin
            phase_nxt = PH_TRAIL;
          end else begin
            phase_nxt = PH_ERR;
          end
        end
        PH_TRAIL: begin
          if (!is_space(ch)) phase_nxt = PH_ERR;
        end
        default: begin
          phase_nxt = PH_ERR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      neg_r   <= 1'b0;
      accum_r <= 64'd0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      accum_r <= accum_nxt;
    end
  end

endmodule
